@@ design/hts_pkg.sv @@
// Shared types and character constants for the HTML tag stripper.
// No dependencies; used by html_tag_stripper.
package hts_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_FINISH
    } hts_state_t;

    localparam int WIN_DEPTH = 6;

    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_P     = 8'h70;  // 'p'
    localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

    // entity bodies that follow '&'
    localparam logic [7:0] ENT_LT   [3] = '{8'h6C, 8'h74, 8'h3B};               // lt;
    localparam logic [7:0] ENT_GT   [3] = '{8'h67, 8'h74, 8'h3B};               // gt;
    localparam logic [7:0] ENT_NBSP [5] = '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}; // nbsp;

endpackage

@@ design/html_tag_stripper.sv @@
// HTML tag stripper: streams text bytes, drops markup, resolves entities.
// Depends on hts_pkg (state type, character constants).
//
//  channel | ports                                   | carries
//  --------+-----------------------------------------+-------------------------------
//  input   | s_valid s_ready s_text_byte s_end_of_text | one text byte or end marker
//  output  | m_valid m_ready m_out_byte m_byte_valid   | one emitted character, or the
//          | m_done_res                              | final done beat after end
//
// A text byte is accepted in idle, then resolved one step per token ('<', '>', plain byte,
// dropped '&' or whole entity) until a step finds the window empty or waiting.
// One compare/shift unit over the window does each step.
// End of text also resolves the window, then a finish state sends the done beat.
// aresetn is synchronous, active low; it clears the tag flag, the window count and
// the output valid. A full output register stalls the resolve step and the done beat.
module html_tag_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_done_res
);

    hts_pkg::hts_state_t state_reg, state_next;

    logic       final_reg, final_next;
    logic       in_tag_reg, in_tag_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] win_reg  [hts_pkg::WIN_DEPTH];
    logic [7:0] win_next [hts_pkg::WIN_DEPTH];
    logic [7:0] win_pop1 [hts_pkg::WIN_DEPTH];
    logic [7:0] win_pop4 [hts_pkg::WIN_DEPTH];

    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       done_reg, done_next;

    logic       out_free;
    logic [2:0] avail;
    logic       lt_ok, gt_ok, nb_ok;
    logic       lt_full, gt_full, nb_full, any_part;

    assign s_ready      = (state_reg == hts_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_done_res   = done_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // shifted copies of the window for pop by one and by four
    always_comb begin
        for (int i = 0; i < hts_pkg::WIN_DEPTH; i++) begin
            win_pop1[i] = win_reg[i];
            win_pop4[i] = win_reg[i];
        end
        for (int i = 0; i < hts_pkg::WIN_DEPTH - 1; i++) begin
            win_pop1[i] = win_reg[i + 1];
        end
        for (int i = 0; i < hts_pkg::WIN_DEPTH - 4; i++) begin
            win_pop4[i] = win_reg[i + 4];
        end
    end

    // entity compare: bytes after the '&' against each entity body
    assign avail = cnt_reg - 3'd1;

    always_comb begin
        lt_ok = 1'b1;
        gt_ok = 1'b1;
        nb_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (avail > 3'(i) && win_reg[i + 1] != hts_pkg::ENT_LT[i]) begin
                lt_ok = 1'b0;
            end
            if (avail > 3'(i) && win_reg[i + 1] != hts_pkg::ENT_GT[i]) begin
                gt_ok = 1'b0;
            end
        end
        for (int i = 0; i < 5; i++) begin
            if (avail > 3'(i) && win_reg[i + 1] != hts_pkg::ENT_NBSP[i]) begin
                nb_ok = 1'b0;
            end
        end
    end

    assign lt_full  = lt_ok && (avail >= 3'd3);
    assign gt_full  = gt_ok && (avail >= 3'd3);
    assign nb_full  = nb_ok && (avail >= 3'd5);
    assign any_part = (lt_ok && avail < 3'd3) || (gt_ok && avail < 3'd3)
                    || (nb_ok && avail < 3'd5);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hts_pkg::ST_IDLE;
            final_reg   <= 1'b0;
            in_tag_reg  <= 1'b0;
            cnt_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            final_reg   <= final_next;
            in_tag_reg  <= in_tag_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg        <= win_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        done_reg       <= done_next;
    end

    always_comb begin
        state_next      = state_reg;
        final_next      = final_reg;
        in_tag_next     = in_tag_reg;
        cnt_next        = cnt_reg;
        win_next        = win_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        done_next       = done_reg;

        unique case (state_reg)
            hts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_end_of_text) begin
                        final_next = 1'b1;
                    end else begin
                        final_next = 1'b0;
                        // drop the byte if the window is full
                        if (cnt_reg < 3'(hts_pkg::WIN_DEPTH)) begin
                            win_next[cnt_reg] = s_text_byte;
                            cnt_next          = cnt_reg + 3'd1;
                        end
                    end
                    state_next = hts_pkg::ST_RESOLVE;
                end
            end

            hts_pkg::ST_RESOLVE: begin
                if (out_free) begin
                    priority if (cnt_reg == 3'd0) begin
                        state_next = final_reg ? hts_pkg::ST_FINISH : hts_pkg::ST_IDLE;
                    end else if (win_reg[0] == hts_pkg::CH_LT) begin
                        if (cnt_reg < 3'd2 && !final_reg) begin
                            state_next = hts_pkg::ST_IDLE;
                        end else begin
                            in_tag_next = 1'b1;
                            if (cnt_reg >= 3'd2 && win_reg[1] == hts_pkg::CH_P) begin
                                m_valid_next    = 1'b1;
                                out_byte_next   = hts_pkg::CH_NL;
                                byte_valid_next = 1'b1;
                                done_next       = 1'b0;
                            end
                            win_next = win_pop1;
                            cnt_next = cnt_reg - 3'd1;
                        end
                    end else if (win_reg[0] == hts_pkg::CH_AMP) begin
                        priority if (lt_full || gt_full) begin
                            in_tag_next = lt_full;
                            win_next    = win_pop4;
                            cnt_next    = cnt_reg - 3'd4;
                        end else if (nb_full) begin
                            cnt_next = 3'd0;
                        end else if (any_part && !final_reg) begin
                            state_next = hts_pkg::ST_IDLE;
                        end else begin
                            // no entity: drop the '&', replay the rest
                            win_next = win_pop1;
                            cnt_next = cnt_reg - 3'd1;
                        end
                    end else if (win_reg[0] == hts_pkg::CH_GT) begin
                        in_tag_next = 1'b0;
                        win_next    = win_pop1;
                        cnt_next    = cnt_reg - 3'd1;
                    end else begin
                        if (!in_tag_reg) begin
                            m_valid_next    = 1'b1;
                            out_byte_next   = (win_reg[0] == hts_pkg::CH_NL) ?
                                              hts_pkg::CH_SPACE : win_reg[0];
                            byte_valid_next = 1'b1;
                            done_next       = 1'b0;
                        end
                        win_next = win_pop1;
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
            end

            hts_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_byte_next   = 8'd0;
                    byte_valid_next = 1'b0;
                    done_next       = 1'b1;
                    in_tag_next     = 1'b0;
                    cnt_next        = 3'd0;
                    final_next      = 1'b0;
                    state_next      = hts_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = hts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/hts_checker.sv @@
// Port-level checks for html_tag_stripper, attached by bind.
// Depends only on the top level's ports.
module hts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_text,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_done_res
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_byte_valid) && $stable(m_done_res))
        else $error("result beat changed while stalled");

    // the done beat carries no character
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_byte_valid && m_out_byte == 8'd0)
        else $error("done beat carries a character");

    // every beat without a character is the done beat
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_done_res)
        else $error("empty beat without done");

    // an end marker keeps the block busy while it flushes
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_text |=> !s_ready)
        else $error("input taken right after end marker");

endmodule

bind html_tag_stripper hts_checker u_hts_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_end_of_text (s_end_of_text),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_byte_valid  (m_byte_valid),
    .m_done_res    (m_done_res)
);

@@ sim/html_tag_stripper_tb.sv @@
// Self-checking testbench for html_tag_stripper: random and directed text streams.
// Depends on hts_pkg (character constants) and the html_tag_stripper RTL.
`timescale 1ns / 100ps

module html_tag_stripper_tb;

    localparam int LIMIT_CYCLES = 300000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int TARGET_ITEMS = 360;
    localparam string ENT_LT_S   = "lt;";
    localparam string ENT_GT_S   = "gt;";
    localparam string ENT_NBSP_S = "nbsp;";

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       done;
    } plain_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_done_res;

    text_item_t  text_q[$];
    plain_beat_t plain_q[$];
    int          n_items;
    int          n_sent = 0;
    int          err_cnt = 0;
    int          cyc = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // stripper state mirrored by the predictor
    bit          tag_open = 1'b0;
    logic [7:0]  win [hts_pkg::WIN_DEPTH];
    int unsigned win_n = 0;

    html_tag_stripper dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_done_res    (m_done_res)
    );

    always #2 aclk = ~aclk;

    function automatic int idle_phase();
        if (n_sent * 3 < n_items) begin
            return 0;
        end else if (n_sent * 3 < 2 * n_items) begin
            return 1;
        end
        return 2;
    endfunction

    function automatic void emit_plain(logic [7:0] ch, logic vld, logic done);
        plain_beat_t b;
        b.ch = ch;
        b.vld = vld;
        b.done = done;
        plain_q.push_back(b);
    endfunction

    function automatic void drop_front(int unsigned k);
        if (k >= win_n) begin
            win_n = 0;
            return;
        end
        for (int unsigned i = 0; i < win_n - k; i++) begin
            win[i] = win[i + k];
        end
        win_n -= k;
    endfunction

    // 0: no match, 1: still a proper prefix, 2: full entity
    function automatic int entity_state(string pat);
        int unsigned avail;
        int unsigned m;
        avail = win_n - 1;
        m = (avail < pat.len()) ? avail : pat.len();
        for (int unsigned i = 0; i < m; i++) begin
            if (win[1 + i] != pat[i]) return 0;
        end
        return (avail >= pat.len()) ? 2 : 1;
    endfunction

    function automatic void resolve_window(bit flush);
        logic [7:0] h;
        int rl;
        int rg;
        int rn;
        while (win_n > 0) begin
            h = win[0];
            if (h == hts_pkg::CH_LT) begin
                if (win_n < 2 && !flush) break;
                tag_open = 1'b1;
                if (win_n >= 2 && win[1] == hts_pkg::CH_P) begin
                    emit_plain(hts_pkg::CH_NL, 1'b1, 1'b0);
                end
                drop_front(1);
            end else if (h == hts_pkg::CH_AMP) begin
                rl = entity_state(ENT_LT_S);
                rg = entity_state(ENT_GT_S);
                rn = entity_state(ENT_NBSP_S);
                if (rl == 2) begin
                    tag_open = 1'b1;
                    drop_front(4);
                end else if (rg == 2) begin
                    tag_open = 1'b0;
                    drop_front(4);
                end else if (rn == 2) begin
                    drop_front(6);
                end else if ((rl == 1 || rg == 1 || rn == 1) && !flush) begin
                    break;
                end else begin
                    drop_front(1);
                end
            end else if (h == hts_pkg::CH_GT) begin
                tag_open = 1'b0;
                drop_front(1);
            end else if (h == hts_pkg::CH_NL) begin
                if (!tag_open) emit_plain(hts_pkg::CH_SPACE, 1'b1, 1'b0);
                drop_front(1);
            end else begin
                if (!tag_open) emit_plain(h, 1'b1, 1'b0);
                drop_front(1);
            end
        end
    endfunction

    function automatic void predict_plain(text_item_t it);
        if (it.eot) begin
            resolve_window(1'b1);
            emit_plain(8'h00, 1'b0, 1'b1);
            tag_open = 1'b0;
            win_n = 0;
            return;
        end
        if (win_n < hts_pkg::WIN_DEPTH) begin
            win[win_n] = it.text;
            win_n++;
        end
        resolve_window(1'b0);
    endfunction

    task automatic add_char(logic [7:0] ch);
        text_item_t it;
        it.text = ch;
        it.eot = 1'b0;
        text_q.push_back(it);
    endtask

    task automatic add_end();
        text_item_t it;
        it.text = 8'($urandom_range(255));
        it.eot = 1'b1;
        text_q.push_back(it);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    function automatic string pick_entity();
        case ($urandom_range(2))
            0: return ENT_LT_S;
            1: return ENT_GT_S;
            default: return ENT_NBSP_S;
        endcase
    endfunction

    task automatic add_random_text();
        string e;
        int k;
        while (text_q.size() < TARGET_ITEMS - 1) begin
            if ($urandom_range(14) == 0) begin
                add_end();
            end else begin
                case ($urandom_range(9))
                    0, 1: add_char(rand_letter());
                    2: add_char(8'($urandom_range(255)));
                    3: add_text("<p");
                    4: begin
                        add_char(hts_pkg::CH_LT);
                        add_char(rand_letter());
                    end
                    5: add_char(hts_pkg::CH_GT);
                    6: begin
                        add_char(hts_pkg::CH_AMP);
                        add_text(pick_entity());
                    end
                    7: begin
                        // broken entity: a proper prefix, then a stray byte
                        e = pick_entity();
                        k = $urandom_range(e.len() - 1, 1);
                        add_char(hts_pkg::CH_AMP);
                        add_text(e.substr(0, k - 1));
                        add_char(rand_letter());
                    end
                    8: add_char(hts_pkg::CH_NL);
                    default: add_char(hts_pkg::CH_AMP);
                endcase
            end
        end
        add_end();
    endtask

    // sender: offer the next beat once the current one is taken
    always @(posedge aclk) begin
        text_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.text = s_text_byte;
                it.eot = s_end_of_text;
                predict_plain(it);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (text_q.size() != 0 &&
                    $urandom_range(99) >= ((idle_phase() == 0) ? 12 :
                                           (idle_phase() == 1) ? 76 : 0)) begin
                    it = text_q.pop_front();
                    s_text_byte <= it.text;
                    s_end_of_text <= it.eot;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off early in the no-idle phase
    always @(posedge aclk) begin
        if (!hold_done && idle_phase() == 2 && n_sent * 3 >= 2 * n_items + 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= ((idle_phase() == 0) ? 76 :
                                              (idle_phase() == 1) ? 12 : 0);
        end
    end

    always @(posedge aclk) begin
        plain_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (plain_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected beat ch=%h vld=%b done=%b",
                         $time, m_out_byte, m_byte_valid, m_done_res);
            end else begin
                want = plain_q.pop_front();
                if (m_out_byte !== want.ch || m_byte_valid !== want.vld ||
                    m_done_res !== want.done) begin
                    err_cnt++;
                    $display({"%0t: mismatch expected ch=%h vld=%b done=%b, ",
                              "got ch=%h vld=%b done=%b"},
                             $time, want.ch, want.vld, want.done,
                             m_out_byte, m_byte_valid, m_done_res);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // tags, paragraph break, newline in and out of a tag, all three entities,
        // a dropped ampersand, a zero byte, a trailing '<' and a trailing partial entity
        add_text("<p>");
        add_char(hts_pkg::CH_NL);
        add_char(hts_pkg::CH_AMP);
        add_text(ENT_LT_S);
        add_char(hts_pkg::CH_NL);
        add_char(hts_pkg::CH_AMP);
        add_text(ENT_GT_S);
        add_char(hts_pkg::CH_AMP);
        add_text(ENT_NBSP_S);
        add_text("&x");
        add_char(8'h00);
        add_char(hts_pkg::CH_LT);
        add_end();
        add_text("&n");
        add_end();
        add_random_text();
        n_items = text_q.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_valid) @(posedge aclk);
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && plain_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
